[hw/rtl/m2r_pkg.sv]
// Shared types and constants for the monochrome to RGB565 window stream.
// Used by every module in hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package m2r_pkg;

    localparam int COORD_W    = 16;
    localparam int MONO_W     = 8;
    localparam int IN_DATA_W  = 4 * COORD_W + MONO_W;   // 72, whole bytes
    localparam int PIX_W      = 33;                     // window area up to 2^32
    localparam int CNT_W      = 4;                      // pixels per request, 0..8
    localparam int IDX_W      = 5;                      // output byte index, 0..15
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;

    localparam logic [PIX_W-1:0] PIX_PER_BYTE = PIX_W'(MONO_W);
    localparam logic [CNT_W-1:0] MAX_COUNT    = CNT_W'(MONO_W);

    // input request kind, carried on s_axis_tuser
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_FRAME = 1'b1
    } cmd_t;

    // kind of work queued between front and back
    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_PIXELS = 1'b1
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR   = 3'd0,
        CFG_BG_COLOR   = 3'd1,
        CFG_COLUMN_CMD = 3'd2,
        CFG_ROW_CMD    = 3'd3,
        CFG_WRITE_CMD  = 3'd4
    } cfg_idx_t;

    // header byte positions
    localparam logic [IDX_W-1:0] HDR_COLUMN_CMD = 5'd0;
    localparam logic [IDX_W-1:0] HDR_XS_HI      = 5'd1;
    localparam logic [IDX_W-1:0] HDR_XS_LO      = 5'd2;
    localparam logic [IDX_W-1:0] HDR_XE_HI      = 5'd3;
    localparam logic [IDX_W-1:0] HDR_XE_LO      = 5'd4;
    localparam logic [IDX_W-1:0] HDR_ROW_CMD    = 5'd5;
    localparam logic [IDX_W-1:0] HDR_YS_HI      = 5'd6;
    localparam logic [IDX_W-1:0] HDR_YS_LO      = 5'd7;
    localparam logic [IDX_W-1:0] HDR_YE_HI      = 5'd8;
    localparam logic [IDX_W-1:0] HDR_YE_LO      = 5'd9;
    localparam logic [IDX_W-1:0] HDR_WRITE_CMD  = 5'd10;

    typedef struct packed {
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [7:0]  column_cmd;
        logic [7:0]  row_cmd;
        logic [7:0]  write_cmd;
    } cfg_t;

    // header: data = {y_end, y_start, x_end, x_start}
    // pixels: data[7:0] = mono byte, count = pixels to send, done = window ends here
    typedef struct packed {
        kind_t            kind;
        logic [63:0]      data;
        logic [CNT_W-1:0] count;
        logic             done;
    } qentry_t;

endpackage

[hw/rtl/m2r_front.sv]
// Front end: accepts requests, tracks the remaining window pixel count and
// queues header or pixel work. Depends on m2r_pkg.
`timescale 1ns / 1ps

module m2r_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_cmd,
    input  logic [m2r_pkg::IN_DATA_W-1:0]  in_data,
    output logic                           push_valid,
    input  logic                           push_ready,
    output m2r_pkg::qentry_t               push_entry
);

    logic [m2r_pkg::PIX_W-1:0] pixels_left_reg;
    logic [m2r_pkg::PIX_W-1:0] pixels_left_next;

    logic [15:0] xs, ys, xe, ye;
    logic [16:0] width, height;
    logic [33:0] area;
    logic        window_ok;
    logic        accept;
    logic        is_start;
    logic        have_pixels;
    logic [m2r_pkg::CNT_W-1:0] count;

    assign xs = in_data[15:0];
    assign ys = in_data[31:16];
    assign xe = in_data[47:32];
    assign ye = in_data[63:48];

    assign width     = {1'b0, xe} - {1'b0, xs} + 17'd1;
    assign height    = {1'b0, ye} - {1'b0, ys} + 17'd1;
    assign area      = width * height;
    assign window_ok = (xe >= xs) && (ye >= ys);

    assign in_ready    = push_ready;
    assign accept      = in_valid && in_ready;
    assign is_start    = (in_cmd == m2r_pkg::CMD_START);
    assign have_pixels = (pixels_left_reg != '0);

    always_comb
    begin
        if (pixels_left_reg >= m2r_pkg::PIX_PER_BYTE)
            count = m2r_pkg::MAX_COUNT;
        else
            count = pixels_left_reg[m2r_pkg::CNT_W-1:0];
    end

    // frame byte with an empty window yields nothing, so nothing is queued
    assign push_valid = accept && (is_start || have_pixels);

    always_comb
    begin
        push_entry.data = {ye, ys, xe, xs};
        if (is_start)
        begin
            push_entry.kind  = m2r_pkg::KIND_HEADER;
            push_entry.count = '0;
            push_entry.done  = 1'b0;
        end
        else
        begin
            push_entry.kind  = m2r_pkg::KIND_PIXELS;
            push_entry.data  = {56'd0, in_data[71:64]};
            push_entry.count = count;
            push_entry.done  = (pixels_left_reg <= m2r_pkg::PIX_PER_BYTE);
        end
    end

    always_comb
    begin
        pixels_left_next = pixels_left_reg;
        if (accept)
        begin
            if (is_start)
                pixels_left_next = window_ok ? area[m2r_pkg::PIX_W-1:0] : '0;
            else
                pixels_left_next = pixels_left_reg - {29'd0, count};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixels_left_reg <= '0;
        else
            pixels_left_reg <= pixels_left_next;
    end

endmodule

[hw/rtl/m2r_queue.sv]
// Two-entry queue of work between the front and back ends.
// Depends on m2r_pkg.
`timescale 1ns / 1ps

module m2r_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  m2r_pkg::qentry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output m2r_pkg::qentry_t pop_entry
);

    m2r_pkg::qentry_t mem_reg [m2r_pkg::QDEPTH];

    logic [m2r_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [m2r_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [m2r_pkg::QPTR_W:0]   fill_reg, fill_next;
    logic push, pop;

    assign push_ready = (fill_reg != (m2r_pkg::QPTR_W + 1)'(m2r_pkg::QDEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[hw/rtl/m2r_back.sv]
// Back end: walks each queued entry one output byte per cycle, unless the
// output stalls, into the output register. Depends on m2r_pkg.
`timescale 1ns / 1ps

module m2r_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  m2r_pkg::cfg_t    cfg,
    input  logic             q_valid,
    output logic             q_ready,
    input  m2r_pkg::qentry_t q_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_is_command,
    output logic             out_last,
    output logic             out_frame_done
);

    logic [m2r_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       cmd_reg, cmd_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;

    logic       step;
    logic       final_byte;
    logic [15:0] color;
    logic [m2r_pkg::IDX_W-1:0] pix_last_idx;

    assign step = q_valid && (!valid_reg || out_ready);

    assign pix_last_idx = {q_entry.count, 1'b0} - 5'd1;
    assign color = q_entry.data[idx_reg[3:1]] ? cfg.fg_color : cfg.bg_color;

    always_comb
    begin
        byte_next  = byte_reg;
        cmd_next   = 1'b0;
        final_byte = 1'b0;
        if (q_entry.kind == m2r_pkg::KIND_HEADER)
        begin
            final_byte = (idx_reg == m2r_pkg::HDR_WRITE_CMD);
            case (idx_reg)
                m2r_pkg::HDR_COLUMN_CMD:
                begin
                    byte_next = cfg.column_cmd;
                    cmd_next  = 1'b1;
                end
                m2r_pkg::HDR_XS_HI: byte_next = q_entry.data[15:8];
                m2r_pkg::HDR_XS_LO: byte_next = q_entry.data[7:0];
                m2r_pkg::HDR_XE_HI: byte_next = q_entry.data[31:24];
                m2r_pkg::HDR_XE_LO: byte_next = q_entry.data[23:16];
                m2r_pkg::HDR_ROW_CMD:
                begin
                    byte_next = cfg.row_cmd;
                    cmd_next  = 1'b1;
                end
                m2r_pkg::HDR_YS_HI: byte_next = q_entry.data[47:40];
                m2r_pkg::HDR_YS_LO: byte_next = q_entry.data[39:32];
                m2r_pkg::HDR_YE_HI: byte_next = q_entry.data[63:56];
                m2r_pkg::HDR_YE_LO: byte_next = q_entry.data[55:48];
                m2r_pkg::HDR_WRITE_CMD:
                begin
                    byte_next = cfg.write_cmd;
                    cmd_next  = 1'b1;
                end
                default: byte_next = cfg.write_cmd;
            endcase
        end
        else
        begin
            // high byte of each colour first
            final_byte = (idx_reg == pix_last_idx);
            byte_next  = idx_reg[0] ? color[7:0] : color[15:8];
        end
    end

    assign last_next = final_byte;
    assign done_next = final_byte && q_entry.done &&
                       (q_entry.kind == m2r_pkg::KIND_PIXELS);
    assign q_ready   = step && final_byte;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (step)
        begin
            idx_next   = final_byte ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_reg <= byte_next;
            cmd_reg  <= cmd_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_is_command = cmd_reg;
    assign out_last       = last_reg;
    assign out_frame_done = done_reg;

endmodule

[hw/rtl/mono_to_rgb565_window_stream.sv]
// Top level of the monochrome to RGB565 window stream.
// Depends on m2r_pkg, m2r_front, m2r_queue and m2r_back.
`timescale 1ns / 1ps

// A start request (tuser = 0) sends an 11-byte window header: column command,
// x_start and x_end big-endian, row command, y_start and y_end big-endian,
// then the memory-write command; the three command bytes carry is_command.
// It also loads the pixel count with the window area (zero if the window is
// inverted); a new start drops whatever was left of the previous window.
// A frame-byte request (tuser = 1) expands its bits LSB first into colours,
// foreground for a set bit and background for a clear one, high byte first,
// up to 8 pixels or until the count runs out; with nothing left it yields no
// output. tlast marks the final byte of each request, tuser[1] the low byte
// of the window's final pixel. Output runs one byte per cycle unless
// m_axis_tready stalls it: 11 bytes per header, 2 per pixel of a frame
// byte, up to 16; the back-end byte walker sets the rate. The front end
// takes a new request every cycle while the two-entry queue has room;
// requests pass the queue, then the output register. Configuration is written
// by the user through cfg_we/cfg_index/cfg_data while idle; not enforced.

module mono_to_rgb565_window_stream
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [m2r_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [m2r_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] x_start, [31:16] y_start, [47:32] x_end, [63:48] y_end,
    // [71:64] mono_byte
    input  logic [m2r_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] command
    input  logic                             s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]                       m_axis_tdata,
    // [0] is_command, [1] frame_done
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    m2r_pkg::cfg_t    cfg_reg;
    m2r_pkg::qentry_t push_entry;
    m2r_pkg::qentry_t pop_entry;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    logic is_command, frame_done;

    // configuration registers; writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color   <= 16'hFFFF;
            cfg_reg.bg_color   <= 16'h0000;
            cfg_reg.column_cmd <= 8'd42;
            cfg_reg.row_cmd    <= 8'd43;
            cfg_reg.write_cmd  <= 8'd44;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                m2r_pkg::CFG_FG_COLOR:   cfg_reg.fg_color   <= cfg_data;
                m2r_pkg::CFG_BG_COLOR:   cfg_reg.bg_color   <= cfg_data;
                m2r_pkg::CFG_COLUMN_CMD: cfg_reg.column_cmd <= cfg_data[7:0];
                m2r_pkg::CFG_ROW_CMD:    cfg_reg.row_cmd    <= cfg_data[7:0];
                m2r_pkg::CFG_WRITE_CMD:  cfg_reg.write_cmd  <= cfg_data[7:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    m2r_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    m2r_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    m2r_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_entry        (pop_entry),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_is_command (is_command),
        .out_last       (m_axis_tlast),
        .out_frame_done (frame_done)
    );

    assign m_axis_tuser = {frame_done, is_command};

endmodule
